// ===== hdl/bld_pkg.sv =====
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types, widths and register codes for the backlight idle dimmer.
// ----------------------------------------------------------------------------
package bld_pkg;

	localparam int NOW_W     = 48;
	localparam int DELAY_W   = 48;
	localparam int LEVEL_W   = 7;
	localparam int CFG_DATA_W = 48;
	localparam int TIME_BITS_DEF = 48;

	typedef enum logic [2:0] {
		CFG_NIGHT_DELAY = 3'd0,
		CFG_WAKE_HOLD   = 3'd1,
		CFG_DAY_LEVEL   = 3'd2,
		CFG_NIGHT_LEVEL = 3'd3,
		CFG_RISE_STEP   = 3'd4,
		CFG_FALL_STEP   = 3'd5
	} cfg_idx_t;

	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	localparam logic [DELAY_W-1:0] NIGHT_DELAY_RST = DELAY_W'(900000000);
	localparam logic [DELAY_W-1:0] WAKE_HOLD_RST   = DELAY_W'(30000000);
	localparam logic [LEVEL_W-1:0] DAY_LEVEL_RST   = LEVEL_W'(100);
	localparam logic [LEVEL_W-1:0] NIGHT_LEVEL_RST = LEVEL_W'(20);
	localparam logic [LEVEL_W-1:0] RISE_STEP_RST   = LEVEL_W'(8);
	localparam logic [LEVEL_W-1:0] FALL_STEP_RST   = LEVEL_W'(1);

	typedef struct packed {
		logic               action;
		logic [NOW_W-1:0]   now_us;
		logic               touch_pressed;
		logic               key_pressed;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] brightness;
		logic               brightness_changed;
		logic               next_app;
		logic               dimmed_target;
	} result_t;

	typedef struct packed {
		cfg_idx_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_req_t;

	typedef struct packed {
		logic [DELAY_W-1:0] night_delay_us;
		logic [DELAY_W-1:0] touch_hold_us;
		logic [LEVEL_W-1:0] day_level;
		logic [LEVEL_W-1:0] night_level;
		logic [LEVEL_W-1:0] rise_step;
		logic [LEVEL_W-1:0] fall_step;
	} cfg_regs_t;

endpackage

// ===== hdl/bld_chan_if.sv =====
// ----------------------------------------------------------------------------
// bld_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface bld_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/bld_cfg.sv =====
// ----------------------------------------------------------------------------
// bld_cfg
// Configuration register file, written through its own request channel.
// ----------------------------------------------------------------------------
module bld_cfg (
	input  logic              clk,
	input  logic              arst_n,
	bld_chan_if.sink          cfg,
	output bld_pkg::cfg_regs_t regs
);
	bld_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.night_delay_us <= bld_pkg::NIGHT_DELAY_RST;
			regs_q.touch_hold_us  <= bld_pkg::WAKE_HOLD_RST;
			regs_q.day_level      <= bld_pkg::DAY_LEVEL_RST;
			regs_q.night_level    <= bld_pkg::NIGHT_LEVEL_RST;
			regs_q.rise_step      <= bld_pkg::RISE_STEP_RST;
			regs_q.fall_step      <= bld_pkg::FALL_STEP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				bld_pkg::CFG_NIGHT_DELAY: begin
					regs_q.night_delay_us <= bld_pkg::DELAY_W'(cfg.payload.data);
				end
				bld_pkg::CFG_WAKE_HOLD: begin
					regs_q.touch_hold_us <= bld_pkg::DELAY_W'(cfg.payload.data);
				end
				bld_pkg::CFG_DAY_LEVEL: begin
					regs_q.day_level <= cfg.payload.data[bld_pkg::LEVEL_W-1:0];
				end
				bld_pkg::CFG_NIGHT_LEVEL: begin
					regs_q.night_level <= cfg.payload.data[bld_pkg::LEVEL_W-1:0];
				end
				bld_pkg::CFG_RISE_STEP: begin
					regs_q.rise_step <= cfg.payload.data[bld_pkg::LEVEL_W-1:0];
				end
				bld_pkg::CFG_FALL_STEP: begin
					regs_q.fall_step <= cfg.payload.data[bld_pkg::LEVEL_W-1:0];
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end
endmodule

// ===== hdl/bld_core.sv =====
// ----------------------------------------------------------------------------
// bld_core
// Input register, idle decision and level ramp, result register.
// ----------------------------------------------------------------------------
module bld_core #(
	parameter int TIME_BITS = bld_pkg::TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bld_pkg::cfg_regs_t regs,
	bld_chan_if.sink           item,
	bld_chan_if.source         result
);
	localparam int CMP_W = (TIME_BITS > bld_pkg::NOW_W) ? TIME_BITS : bld_pkg::NOW_W;
	localparam int LW    = bld_pkg::LEVEL_W;

	// input stage
	logic           valid_s1;
	bld_pkg::item_t item_s1;

	// block state
	logic [TIME_BITS-1:0] last_act_q;
	logic [TIME_BITS-1:0] last_touch_q;
	logic [LW-1:0]        level_q;
	logic                 key_was_q;

	// result register
	logic             res_valid_q;
	bld_pkg::result_t res_q;

	logic adv;
	logic take;
	logic fire;

	assign adv        = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || adv;
	assign take       = item.valid && item.ready;
	assign fire       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item.payload;
		end
	end

	// single-pass evaluation of the held request
	logic [CMP_W-1:0]     now_ext;
	logic [TIME_BITS-1:0] now_tm;
	logic                 is_tick;
	logic                 key_edge;
	logic                 touched;
	logic [TIME_BITS-1:0] touch_ref;
	logic [TIME_BITS-1:0] act_gap;
	logic [TIME_BITS-1:0] touch_gap;
	logic                 dimmed;
	logic [LW-1:0]        target;
	logic [LW:0]          up_sum;
	logic [LW:0]          down_lim;
	logic [LW-1:0]        level_nxt;
	logic                 changed;

	assign now_ext   = CMP_W'(item_s1.now_us);
	assign now_tm    = TIME_BITS'(now_ext);
	assign is_tick   = (item_s1.action == bld_pkg::ACT_TICK);
	assign key_edge  = item_s1.key_pressed && !key_was_q;
	assign touched   = item_s1.touch_pressed || key_edge;
	assign touch_ref = touched ? now_tm : last_touch_q;
	assign act_gap   = now_tm - last_act_q;
	assign touch_gap = now_tm - touch_ref;

	assign dimmed = (CMP_W'(act_gap) > CMP_W'(regs.night_delay_us)) &&
	                (CMP_W'(touch_gap) > CMP_W'(regs.touch_hold_us));
	assign target = dimmed ? regs.night_level : regs.day_level;

	assign up_sum   = {1'b0, level_q} + {1'b0, regs.rise_step};
	assign down_lim = {1'b0, target} + {1'b0, regs.fall_step};
	assign changed  = (level_q != target);

	always_comb begin
		level_nxt = level_q;
		if (changed) begin
			if (target > level_q) begin
				level_nxt = (up_sum > {1'b0, target}) ? target : up_sum[LW-1:0];
			end else begin
				level_nxt = ({1'b0, level_q} < down_lim) ? target
				                                         : level_q - regs.fall_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_act_q   <= '0;
			last_touch_q <= '0;
			level_q      <= '0;
			key_was_q    <= 1'b0;
		end else if (fire) begin
			if (is_tick) begin
				last_touch_q <= touch_ref;
				level_q      <= level_nxt;
				key_was_q    <= item_s1.key_pressed;
			end else begin
				last_act_q <= now_tm;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.brightness         <= is_tick ? level_nxt : level_q;
			res_q.brightness_changed <= is_tick && changed;
			res_q.next_app           <= is_tick && key_edge;
			res_q.dimmed_target      <= is_tick && dimmed;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	// the shown level is always the live level
	a_level_shown: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.brightness == level_q))
		else $error("result brightness differs from level state");

	// the level only moves on a processed tick
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && is_tick) |=> $stable(level_q))
		else $error("level moved without a tick");

	// activity reports give a quiet result
	a_report_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_tick) |=> (!res_q.brightness_changed && !res_q.next_app &&
		                        !res_q.dimmed_target))
		else $error("activity report flagged a change");

	// a key pulse leaves the key recorded as down
	a_pulse_key: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.next_app) |-> key_was_q)
		else $error("next_app without key held");

	// a held request waits in the input stage
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost a request");
endmodule

// ===== hdl/backlight_idle_dimmer.sv =====
// ----------------------------------------------------------------------------
// backlight_idle_dimmer
// Chooses day or night backlight level from activity and touch idle times
// and ramps the brightness toward it.
// ----------------------------------------------------------------------------
// One request is taken per clock unless the input register holds a stalled
// request; each gives exactly one result, via the input and result registers,
// with the decision and ramp done between them. The state (last activity,
// last touch, level, key) is updated as the result register is loaded, so
// requests may follow back to back. A stalled result still lets one further
// request into the input register. Configuration writes are always ready and
// take effect on the next request; write them only while the block is idle.
module backlight_idle_dimmer #(
	parameter int TIME_BITS = bld_pkg::TIME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bld_chan_if.sink   item,
	bld_chan_if.source result,
	bld_chan_if.sink   cfg
);
	bld_pkg::cfg_regs_t regs;

	bld_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bld_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.item   (item),
		.result (result)
	);
endmodule
